// ===== src/jad_pkg.sv =====
package jad_pkg;

  // Field widths fixed by the item formats.
  localparam int unsigned RawW    = 8;
  localparam int unsigned DirW    = 3;
  localparam int unsigned ScaledW = 8;
  localparam int unsigned MarginW = 6;
  localparam int unsigned ThreshW = 7;
  localparam int unsigned FsW     = 7;
  localparam int unsigned QuotW   = FsW;   // |scaled| never exceeds full_scale
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 7;
  localparam int unsigned StepW   = 3;     // counts the QuotW quotient bits

  // Direction codes.
  localparam logic [DirW-1:0] DIR_NONE  = 3'd0;
  localparam logic [DirW-1:0] DIR_UP    = 3'd1;
  localparam logic [DirW-1:0] DIR_RIGHT = 3'd2;
  localparam logic [DirW-1:0] DIR_DOWN  = 3'd3;
  localparam logic [DirW-1:0] DIR_LEFT  = 3'd4;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_RANGE_MARGIN   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MOVE_THRESHOLD = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_FULL_SCALE     = 2'd2;

  // Register reset values.
  localparam logic [MarginW-1:0] RangeMarginRst   = 6'd10;
  localparam logic [ThreshW-1:0] MoveThresholdRst = 7'd75;
  localparam logic [FsW-1:0]     FullScaleRst     = 7'd127;

endpackage

// ===== src/jad_if.sv =====
// Request channel: one raw stick sample per request.
interface jad_req_if;
  logic                       valid;
  logic                       ready;
  logic                       mode;
  logic [jad_pkg::RawW-1:0]   raw_x;
  logic [jad_pkg::RawW-1:0]   raw_y;

  modport source (output valid, mode, raw_x, raw_y, input ready);
  modport sink   (input valid, mode, raw_x, raw_y, output ready);
endinterface

// Result channel: direction and the two scaled axis values.
interface jad_res_if;
  logic                              valid;
  logic                              ready;
  logic [jad_pkg::DirW-1:0]          direction;
  logic signed [jad_pkg::ScaledW-1:0] scaled_x;
  logic signed [jad_pkg::ScaledW-1:0] scaled_y;

  modport source (output valid, direction, scaled_x, scaled_y, input ready);
  modport sink   (input valid, direction, scaled_x, scaled_y, output ready);
endinterface

// ===== src/joystick_autorange_direction.sv =====
// A sample request runs the multiply and divide steps for each axis in turn, then waits in
// the result stage until the result register can take it; a recenter request goes straight
// to the result stage. A new request is taken only once the previous result is loaded. The
// single shared multiplier and the restoring divider that yields one quotient bit per cycle serve both axes in turn.
// Reset (rst_ni low, asynchronous): registers take their reset values, centers sit at mid-scale
// with bounds at center plus or minus 10, and no result is pending.
module joystick_autorange_direction #(
  parameter int unsigned SAMPLE_BITS = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [jad_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [jad_pkg::CfgDataW-1:0]      cfg_data_i,
  jad_req_if.sink                           req_i,
  jad_res_if.source                         res_o
);

  // Sample width and the part of the raw field that survives the mask.
  localparam int unsigned SW  = SAMPLE_BITS;
  localparam int unsigned InW = (SW < jad_pkg::RawW) ? SW : jad_pkg::RawW;
  // Bounds are signed and must hold center plus or minus the largest margin.
  localparam int unsigned BW  = SW + 2;
  // Half-range denominator and the product that is divided by it.
  localparam int unsigned DW  = SW + 1;
  localparam int unsigned NW  = DW + jad_pkg::QuotW - 1;
  localparam logic [SW-1:0] CenterRst = SW'(1) << (SW - 1);
  localparam logic [jad_pkg::StepW-1:0] LastStep = jad_pkg::StepW'(jad_pkg::QuotW - 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_DIV  = 4'b0100,
    S_DIR  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [jad_pkg::MarginW-1:0] margin_q;
  logic [jad_pkg::ThreshW-1:0] thresh_q;
  logic [jad_pkg::FsW-1:0]     fs_q;

  // Per-axis calibration state; index 0 is horizontal, index 1 vertical.
  logic [SW-1:0]        center_q [2];
  logic signed [BW-1:0] low_q    [2];
  logic signed [BW-1:0] high_q   [2];

  // Working registers of the current request.
  logic                 axis_q;
  logic [SW-1:0]        samp_q   [2];
  logic [jad_pkg::StepW-1:0] step_q;
  logic                 neg_q;
  logic [DW-1:0]        den_q;
  logic [NW-1:0]        rem_q;
  logic [jad_pkg::QuotW-1:0] quot_q;
  logic signed [jad_pkg::ScaledW-1:0] scaled_q [2];

  // Result register.
  logic                                 out_valid_q;
  logic [jad_pkg::DirW-1:0]             out_dir_q;
  logic signed [jad_pkg::ScaledW-1:0]   out_sx_q;
  logic signed [jad_pkg::ScaledW-1:0]   out_sy_q;

  logic [SW-1:0] in_samp [2];
  logic          req_fire;
  logic          out_load;

  assign in_samp[0] = SW'(req_i.raw_x[InW-1:0]);
  assign in_samp[1] = SW'(req_i.raw_y[InW-1:0]);

  // Requests are taken only while the sequencer is idle; the result register
  // decouples the two channels, so a waiting result does not block a request.
  assign req_i.ready = (state_q == S_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;

  // The result is loaded once the previous one has left or is leaving now.
  assign out_load = (state_q == S_DIR) && (!out_valid_q || res_o.ready);

  assign res_o.valid     = out_valid_q;
  assign res_o.direction = out_dir_q;
  assign res_o.scaled_x  = out_sx_q;
  assign res_o.scaled_y  = out_sy_q;

  // Operand selection for the axis being scaled.
  logic [SW-1:0]        cur_v;
  logic [SW-1:0]        cur_c;
  logic signed [BW-1:0] cur_v_s;
  logic signed [BW-1:0] cur_c_s;
  logic                 cur_neg;
  logic [SW-1:0]        cur_diff;
  logic signed [BW-1:0] cur_den_s;
  logic [NW-1:0]        cur_prod;

  always_comb begin
    cur_v     = samp_q[axis_q];
    cur_c     = center_q[axis_q];
    cur_v_s   = $signed({2'b00, cur_v});
    cur_c_s   = $signed({2'b00, cur_c});
    cur_neg   = cur_v < cur_c;
    cur_diff  = cur_neg ? (cur_c - cur_v) : (cur_v - cur_c);
    cur_den_s = cur_neg ? (cur_c_s - low_q[axis_q]) : (high_q[axis_q] - cur_c_s);
    cur_prod  = NW'(cur_diff) * NW'(fs_q);
  end

  // One restoring division step: the quotient is known to fit in QuotW bits
  // because the sample never lies beyond the widened bounds.
  logic [NW-1:0]             den_sh;
  logic                      fits;
  logic [jad_pkg::QuotW-1:0] quot_next;
  logic signed [jad_pkg::ScaledW-1:0] quot_signed;

  always_comb begin
    den_sh      = NW'(den_q) << step_q;
    // An empty half-range only occurs with the sample on the center, which scales to zero.
    fits        = (den_q != '0) && (rem_q >= den_sh);
    quot_next   = {quot_q[jad_pkg::QuotW-2:0], fits};
    quot_signed = $signed({1'b0, quot_next});
    if (neg_q) begin
      quot_signed = -quot_signed;
    end
  end

  // Direction decode, strict compare against plus or minus the threshold.
  logic signed [jad_pkg::ScaledW:0] sx_w;
  logic signed [jad_pkg::ScaledW:0] sy_w;
  logic signed [jad_pkg::ScaledW:0] pos_t;
  logic signed [jad_pkg::ScaledW:0] neg_t;
  logic [jad_pkg::DirW-1:0]         dir;

  always_comb begin
    sx_w  = $signed({scaled_q[0][jad_pkg::ScaledW-1], scaled_q[0]});
    sy_w  = $signed({scaled_q[1][jad_pkg::ScaledW-1], scaled_q[1]});
    pos_t = $signed({2'b00, thresh_q});
    neg_t = -pos_t;
    if (sx_w < neg_t) begin
      dir = jad_pkg::DIR_LEFT;
    end else if (sx_w > pos_t) begin
      dir = jad_pkg::DIR_RIGHT;
    end else if (sy_w < neg_t) begin
      dir = jad_pkg::DIR_DOWN;
    end else if (sy_w > pos_t) begin
      dir = jad_pkg::DIR_UP;
    end else begin
      dir = jad_pkg::DIR_NONE;
    end
  end

  // Sequencer: a sample runs multiply then divide for each axis in turn,
  // a recenter request goes straight to the result stage with zero values.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          state_d = req_i.mode ? S_DIR : S_MUL;
        end
      end
      S_MUL: begin
        state_d = S_DIV;
      end
      S_DIV: begin
        if (step_q == '0) begin
          state_d = axis_q ? S_DIR : S_MUL;
        end
      end
      S_DIR: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state, configuration and calibration state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      axis_q      <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      margin_q    <= jad_pkg::RangeMarginRst;
      thresh_q    <= jad_pkg::MoveThresholdRst;
      fs_q        <= jad_pkg::FullScaleRst;
      for (int i = 0; i < 2; i++) begin
        center_q[i] <= CenterRst;
        low_q[i]    <= $signed({2'b00, CenterRst}) - $signed(BW'(jad_pkg::RangeMarginRst));
        high_q[i]   <= $signed({2'b00, CenterRst}) + $signed(BW'(jad_pkg::RangeMarginRst));
      end
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          jad_pkg::CFG_RANGE_MARGIN:   margin_q <= cfg_data_i[jad_pkg::MarginW-1:0];
          jad_pkg::CFG_MOVE_THRESHOLD: thresh_q <= cfg_data_i[jad_pkg::ThreshW-1:0];
          jad_pkg::CFG_FULL_SCALE:     fs_q     <= cfg_data_i[jad_pkg::FsW-1:0];
          default: ;
        endcase
      end

      if (req_fire) begin
        axis_q <= 1'b0;
        for (int i = 0; i < 2; i++) begin
          if (req_i.mode) begin
            center_q[i] <= in_samp[i];
            low_q[i]    <= $signed({2'b00, in_samp[i]}) - $signed(BW'(margin_q));
            high_q[i]   <= $signed({2'b00, in_samp[i]}) + $signed(BW'(margin_q));
          end else begin
            // Widen the bounds before scaling so the sample always lies within them.
            if ($signed({2'b00, in_samp[i]}) < low_q[i]) begin
              low_q[i] <= $signed({2'b00, in_samp[i]});
            end
            if ($signed({2'b00, in_samp[i]}) > high_q[i]) begin
              high_q[i] <= $signed({2'b00, in_samp[i]});
            end
          end
        end
      end

      if (state_q == S_MUL) begin
        step_q <= LastStep;
      end else if (state_q == S_DIV) begin
        step_q <= step_q - 1'b1;
        if (step_q == '0) begin
          axis_q <= 1'b1;
        end
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      samp_q[0] <= in_samp[0];
      samp_q[1] <= in_samp[1];
      if (req_i.mode) begin
        scaled_q[0] <= '0;
        scaled_q[1] <= '0;
      end
    end

    if (state_q == S_MUL) begin
      neg_q  <= cur_neg;
      den_q  <= cur_den_s[DW-1:0];
      rem_q  <= cur_prod;
      quot_q <= '0;
    end else if (state_q == S_DIV) begin
      quot_q <= quot_next;
      if (fits) begin
        rem_q <= rem_q - den_sh;
      end
      if (step_q == '0) begin
        scaled_q[axis_q] <= quot_signed;
      end
    end

    if (out_load) begin
      out_dir_q <= dir;
      out_sx_q  <= scaled_q[0];
      out_sy_q  <= scaled_q[1];
    end
  end

endmodule
